@@ src/lru_page_replacement_assert.svh @@
// Assertion macros shared by the replacement block.
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

`ifndef ASSERT_OFF

`define LRU_ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

`define LRU_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`else

`define LRU_ASSERT_SAME(label, clk, rst_n, cond, expr)

`define LRU_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

@@ src/lru_pkg.sv @@
`default_nettype none

package lru_pkg;

    localparam int FRAMES          = 8;
    localparam int PAGE_BITS       = 16;
    localparam int TIME_BITS       = 32;
    localparam int FAULT_BITS      = 32;
    localparam int IDX_BITS        = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_BITS        = $clog2(FRAMES + 1);
    localparam int FCOUNT_BITS     = 4;
    localparam int FRAME_IDX_OUT   = 3;
    localparam int EV_PAGE_BITS    = 16;
    localparam int ADDR_BITS       = 3;
    localparam int DATA_BITS       = 32;

    localparam logic REG_FRAME_COUNT = 1'b0;

    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic [CNT_BITS-1:0]  n;
        logic [TIME_BITS-1:0] stamp;
    } lru_req_t;

    typedef struct packed {
        logic                 hit;
        logic [IDX_BITS-1:0]  slot;
        logic                 ev_valid;
        logic [PAGE_BITS-1:0] ev_page;
    } lru_res_t;

    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic [TIME_BITS-1:0] stamp;
    } lru_entry_t;

endpackage

`default_nettype wire

@@ src/lru_page_replacement.sv @@
// Channel   Signals                                     Handshake
// -------   -----------------------------------------   -----------------------------
// input     page_number                                 start && !busy
// result    hit frame_index evicted_valid evicted_page  done, one cycle, no stall
//           fault_count
// config    psel penable pwrite paddr pwdata prdata     psel && penable && pwrite
//
// Each item is walked serially over its n active frames, where n is frame_count
// held to 1..8: S_SCAN reads the active frames through the registered-read frame
// memory, then the S_FINISH state writes the chosen frame back.
// busy drops with the done beat.
// rst_n clears all valid bits, the use counter, the fault counter and sets
// frame_count to 8. The receiver cannot stall; each result shows for one cycle.
`default_nettype none

module lru_page_replacement (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [lru_pkg::PAGE_BITS-1:0]       page_number,
    output logic                                     done,
    output logic                                     hit,
    output logic [lru_pkg::FRAME_IDX_OUT-1:0]        frame_index,
    output logic                                     evicted_valid,
    output logic [lru_pkg::EV_PAGE_BITS-1:0]         evicted_page,
    output logic [lru_pkg::FAULT_BITS-1:0]           fault_count,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lru_pkg::ADDR_BITS-1:0]       paddr,
    input  wire logic [lru_pkg::DATA_BITS-1:0]       pwdata,
    output logic [lru_pkg::DATA_BITS-1:0]            prdata,
    output logic                                     pready
);

    `include "lru_page_replacement_assert.svh"

    logic [lru_pkg::FCOUNT_BITS-1:0] frame_count_reg;
    logic [lru_pkg::TIME_BITS-1:0]   use_reg, use_next;
    logic [lru_pkg::FAULT_BITS-1:0]  faults_reg, faults_next;

    logic                          done_reg;
    logic                          hit_reg;
    logic [lru_pkg::FRAME_IDX_OUT-1:0] frame_index_reg;
    logic                          ev_valid_reg;
    logic [lru_pkg::EV_PAGE_BITS-1:0]  ev_page_reg;
    logic [lru_pkg::FAULT_BITS-1:0]    fault_out_reg;

    logic                 accept;
    logic                 cfg_wr;
    logic                 walk_busy;
    logic                 walk_done;
    lru_pkg::lru_req_t    req;
    lru_pkg::lru_res_t    res;
    logic [lru_pkg::CNT_BITS-1:0] n_active;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == lru_pkg::REG_FRAME_COUNT);
    assign prdata = (paddr[2] == lru_pkg::REG_FRAME_COUNT)
                    ? lru_pkg::DATA_BITS'(frame_count_reg) : '0;

    assign accept = start && !walk_busy;
    assign busy   = walk_busy;

    always_comb
    begin
        if (frame_count_reg == '0)
        begin
            n_active = lru_pkg::CNT_BITS'(1);
        end
        else if (lru_pkg::CNT_BITS'(frame_count_reg) > lru_pkg::CNT_BITS'(lru_pkg::FRAMES)
                 || (lru_pkg::FCOUNT_BITS > lru_pkg::CNT_BITS
                     && (frame_count_reg >> lru_pkg::CNT_BITS) != '0))
        begin
            n_active = lru_pkg::CNT_BITS'(lru_pkg::FRAMES);
        end
        else
        begin
            n_active = lru_pkg::CNT_BITS'(frame_count_reg);
        end
    end

    // Saturate the use counter before stamping.
    assign use_next  = (accept && use_reg != '1) ? use_reg + 1'b1 : use_reg;
    assign req       = '{page: page_number, n: n_active, stamp: use_next};

    assign faults_next = (walk_done && !res.hit && faults_reg != '1)
                         ? faults_reg + 1'b1 : faults_reg;

    lru_walker u_walker (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .req   (req),
        .busy  (walk_busy),
        .done  (walk_done),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= lru_pkg::FCOUNT_BITS'(lru_pkg::FRAMES);
            use_reg         <= '0;
            faults_reg      <= '0;
            done_reg        <= 1'b0;
            hit_reg         <= 1'b0;
            frame_index_reg <= '0;
            ev_valid_reg    <= 1'b0;
            ev_page_reg     <= '0;
            fault_out_reg   <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                frame_count_reg <= pwdata[lru_pkg::FCOUNT_BITS-1:0];
            end
            use_reg    <= use_next;
            faults_reg <= faults_next;
            done_reg   <= walk_done;
            if (walk_done)
            begin
                hit_reg         <= res.hit;
                frame_index_reg <= lru_pkg::FRAME_IDX_OUT'(res.slot);
                ev_valid_reg    <= res.ev_valid;
                ev_page_reg     <= lru_pkg::EV_PAGE_BITS'(res.ev_page);
                fault_out_reg   <= faults_next;
            end
        end
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign frame_index   = frame_index_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign fault_count   = fault_out_reg;

    `LRU_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)
    `LRU_ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy)
    `LRU_ASSERT_SAME(a_evict_miss, clk, rst_n, done && evicted_valid, !hit)
    `LRU_ASSERT_SAME(a_hit_no_fault, clk, rst_n, done && hit,
        fault_count == $past(fault_count))

endmodule

`default_nettype wire

@@ src/lru_walker.sv @@
`default_nettype none

module lru_walker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire lru_pkg::lru_req_t req,
    output logic                  busy,
    output logic                  done,
    output lru_pkg::lru_res_t     res
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } walk_state_t;

    walk_state_t state_reg, state_next;

    lru_pkg::lru_entry_t mem [lru_pkg::FRAMES];
    lru_pkg::lru_entry_t rd_data;

    logic [lru_pkg::FRAMES-1:0]    valid_reg, valid_next;
    logic [lru_pkg::PAGE_BITS-1:0] page_reg, page_next;
    logic [lru_pkg::TIME_BITS-1:0] stamp_reg, stamp_next;
    logic [lru_pkg::CNT_BITS-1:0]  n_reg, n_next;
    logic [lru_pkg::CNT_BITS-1:0]  rd_idx_reg, rd_idx_next;
    logic                          proc_vld_reg, proc_vld_next;
    logic [lru_pkg::IDX_BITS-1:0]  proc_idx_reg, proc_idx_next;
    logic                          found_reg, found_next;
    logic [lru_pkg::IDX_BITS-1:0]  slot_reg, slot_next;
    logic                          empty_reg, empty_next;
    logic [lru_pkg::IDX_BITS-1:0]  empty_idx_reg, empty_idx_next;
    logic                          best_have_reg, best_have_next;
    logic [lru_pkg::TIME_BITS-1:0] best_stamp_reg, best_stamp_next;
    logic [lru_pkg::IDX_BITS-1:0]  best_idx_reg, best_idx_next;
    logic [lru_pkg::PAGE_BITS-1:0] best_page_reg, best_page_next;

    logic                          rd_en;
    logic                          wr_en;
    logic [lru_pkg::IDX_BITS-1:0]  wr_idx;
    logic                          issue;
    logic                          cur_valid;

    assign issue     = (rd_idx_reg != n_reg);
    assign cur_valid = valid_reg[proc_idx_reg];

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        page_next       = page_reg;
        stamp_next      = stamp_reg;
        n_next          = n_reg;
        rd_idx_next     = rd_idx_reg;
        proc_vld_next   = 1'b0;
        proc_idx_next   = proc_idx_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        empty_next      = empty_reg;
        empty_idx_next  = empty_idx_reg;
        best_have_next  = best_have_reg;
        best_stamp_next = best_stamp_reg;
        best_idx_next   = best_idx_reg;
        best_page_next  = best_page_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_idx          = slot_reg;
        done            = 1'b0;
        res             = '0;

        if (proc_vld_reg)
        begin
            if (cur_valid)
            begin
                if (!found_reg && rd_data.page == page_reg)
                begin
                    found_next = 1'b1;
                    slot_next  = proc_idx_reg;
                end
                if (!best_have_reg || rd_data.stamp < best_stamp_reg)
                begin
                    best_have_next  = 1'b1;
                    best_stamp_next = rd_data.stamp;
                    best_idx_next   = proc_idx_reg;
                    best_page_next  = rd_data.page;
                end
            end
            else if (!empty_reg)
            begin
                empty_next     = 1'b1;
                empty_idx_next = proc_idx_reg;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    page_next      = req.page;
                    stamp_next     = req.stamp;
                    n_next         = req.n;
                    rd_idx_next    = '0;
                    found_next     = 1'b0;
                    empty_next     = 1'b0;
                    best_have_next = 1'b0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    rd_en         = 1'b1;
                    rd_idx_next   = rd_idx_reg + 1'b1;
                    proc_vld_next = 1'b1;
                    proc_idx_next = rd_idx_reg[lru_pkg::IDX_BITS-1:0];
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                res.hit = found_reg;
                if (found_reg)
                begin
                    res.slot = slot_reg;
                end
                else if (empty_reg)
                begin
                    res.slot = empty_idx_reg;
                end
                else
                begin
                    res.slot     = best_idx_reg;
                    res.ev_valid = 1'b1;
                    res.ev_page  = best_page_reg;
                end
                wr_en              = 1'b1;
                wr_idx             = res.slot;
                valid_next[wr_idx] = 1'b1;
                done               = 1'b1;
                state_next         = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= '{page: page_reg, stamp: stamp_reg};
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_idx_reg[lru_pkg::IDX_BITS-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            proc_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            proc_vld_reg <= proc_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg       <= page_next;
        stamp_reg      <= stamp_next;
        n_reg          <= n_next;
        rd_idx_reg     <= rd_idx_next;
        proc_idx_reg   <= proc_idx_next;
        found_reg      <= found_next;
        slot_reg       <= slot_next;
        empty_reg      <= empty_next;
        empty_idx_reg  <= empty_idx_next;
        best_have_reg  <= best_have_next;
        best_stamp_reg <= best_stamp_next;
        best_idx_reg   <= best_idx_next;
        best_page_reg  <= best_page_next;
    end

endmodule

`default_nettype wire
